// ===== sv/xnor_popcount_binary_conv_accumulate_assert.svh =====
// ----------------------------------------------------------------------------
// XNOR popcount accumulator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef XNOR_POPCOUNT_BINARY_CONV_ACCUMULATE_ASSERT_SVH
`define XNOR_POPCOUNT_BINARY_CONV_ACCUMULATE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define XPBCA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xpbca assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define XPBCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xpbca assertion failed");

`endif

// ===== sv/xpbca_pkg.sv =====
// ----------------------------------------------------------------------------
// XNOR popcount accumulator package
// Field widths, default parameters, the close record type and the popcount.
// ----------------------------------------------------------------------------
package xpbca_pkg;

  localparam int WORD_W        = 32;
  localparam int COUNT_W       = 17;
  localparam int SCALE_IN_W    = 16;
  localparam int SCALE_W       = 2 * SCALE_IN_W;
  localparam int DIFF_W        = COUNT_W + 2;
  localparam int PROD_W        = DIFF_W + SCALE_W + 1;
  localparam int ACT_W         = 50;
  localparam int POP_W         = $clog2(WORD_W + 1);
  localparam int ACC_FIELD_MAX = (1 << COUNT_W) - 1;

  localparam int DEF_WORD_BITS = 32;
  localparam int DEF_MAX_COUNT = 65536;

  localparam int QUEUE_DEPTH   = 2;

  // Everything the back end needs to scale one closed output position.
  typedef struct packed {
    logic [COUNT_W-1:0]    match_count;
    logic [COUNT_W-1:0]    ops;
    logic [SCALE_IN_W-1:0] alpha;
    logic [SCALE_IN_W-1:0] kscale;
  } close_rec_t;

  // Counts nibbles first, then sums the nibble counts.
  function automatic logic [POP_W-1:0] popcount_word(input logic [WORD_W-1:0] w);
    logic [2:0]       nib;
    logic [POP_W-1:0] total;
    total = '0;
    for (int i = 0; i < WORD_W / 4; i++) begin
      nib = 3'(w[4*i]) + 3'(w[4*i+1]) + 3'(w[4*i+2]) + 3'(w[4*i+3]);
      total = total + POP_W'(nib);
    end
    return total;
  endfunction

endpackage

// ===== sv/xpbca_front.sv =====
// ----------------------------------------------------------------------------
// XNOR popcount accumulator front end
// Registers the popcount of each word, then adds it into the saturating
// match accumulator and hands a close record to the queue on the last word.
// ----------------------------------------------------------------------------
`include "xnor_popcount_binary_conv_accumulate_assert.svh"

module xpbca_front
  import xpbca_pkg::*;
#(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int MAX_COUNT = DEF_MAX_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [WORD_W-1:0]     source_bits,
  input  logic [WORD_W-1:0]     weight_bits,
  input  logic                  tap_in_bounds,
  input  logic                  last_word,
  input  logic [COUNT_W-1:0]    bits_counted,
  input  logic [SCALE_IN_W-1:0] channel_scale,
  input  logic [SCALE_IN_W-1:0] pixel_scale,
  input  logic                  q_ready,
  output logic                  q_push,
  output close_rec_t            q_data
);

  localparam int LIMIT = (MAX_COUNT > ACC_FIELD_MAX) ? ACC_FIELD_MAX : MAX_COUNT;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(LIMIT);
  localparam logic [WORD_W-1:0]  WORD_MASK   = WORD_W'((64'd1 << WORD_BITS) - 64'd1);

  logic                  a_valid;
  logic [POP_W-1:0]      a_pop;
  logic                  a_in_bounds;
  logic                  a_last;
  logic [COUNT_W-1:0]    a_ops;
  logic [SCALE_IN_W-1:0] a_alpha;
  logic [SCALE_IN_W-1:0] a_kscale;
  logic                  a_go;

  logic [COUNT_W-1:0]    acc;
  logic [COUNT_W-1:0]    acc_next;
  logic [COUNT_W:0]      acc_sum;
  logic [COUNT_W-1:0]    acc_new;

  // Only a closing word can stall, and only when the queue is full.
  assign a_go     = !a_last || q_ready;
  assign in_ready = !a_valid || a_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_pop       <= popcount_word(~(source_bits ^ weight_bits) & WORD_MASK);
      a_in_bounds <= tap_in_bounds;
      a_last      <= last_word;
      a_ops       <= bits_counted;
      a_alpha     <= channel_scale;
      a_kscale    <= pixel_scale;
    end
  end

  always_comb begin
    acc_sum = {1'b0, acc} + (COUNT_W + 1)'(a_pop);
    acc_new = acc;
    if (a_in_bounds) begin
      acc_new = (acc_sum > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT : acc_sum[COUNT_W-1:0];
    end
    acc_next = acc;
    if (a_valid && a_go) begin
      acc_next = a_last ? '0 : acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

  assign q_push = a_valid && a_last && q_ready;
  assign q_data = '{match_count: acc_new, ops: a_ops, alpha: a_alpha, kscale: a_kscale};

  `XPBCA_ASSERT_IMPL(acc_within_limit, 1'b1, acc <= COUNT_LIMIT)
  `XPBCA_ASSERT_NEXT(acc_cleared_after_close, q_push, acc == '0)

endmodule

// ===== sv/xpbca_queue.sv =====
// ----------------------------------------------------------------------------
// XNOR popcount accumulator close queue
// Short first-in first-out buffer of close records between front and back.
// ----------------------------------------------------------------------------
`include "xnor_popcount_binary_conv_accumulate_assert.svh"

module xpbca_queue
  import xpbca_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  close_rec_t push_data,
  output logic       push_ready,
  output logic       pop_valid,
  input  logic       pop_ready,
  output close_rec_t pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  close_rec_t       entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `XPBCA_ASSERT_IMPL(no_push_when_full, push, count != CNT_FULL)

endmodule

// ===== sv/xpbca_back.sv =====
// ----------------------------------------------------------------------------
// XNOR popcount accumulator back end
// Three stage scaling pipeline: difference and scale product, full product,
// then saturation into the result register.
// ----------------------------------------------------------------------------
`include "xnor_popcount_binary_conv_accumulate_assert.svh"

module xpbca_back
  import xpbca_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     pop_valid,
  output logic                     pop_ready,
  input  close_rec_t               pop_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [ACT_W-1:0]  activation,
  output logic [COUNT_W-1:0]       match_count
);

  localparam logic signed [PROD_W-1:0] ACT_HI =
    {{(PROD_W - ACT_W + 1){1'b0}}, {(ACT_W - 1){1'b1}}};
  localparam logic signed [PROD_W-1:0] ACT_LO =
    {{(PROD_W - ACT_W + 1){1'b1}}, {(ACT_W - 1){1'b0}}};

  logic                      s1_valid;
  logic signed [DIFF_W-1:0]  s1_diff;
  logic [SCALE_W-1:0]        s1_scale;
  logic [COUNT_W-1:0]        s1_count;
  logic                      s2_valid;
  logic signed [PROD_W-1:0]  s2_prod;
  logic [COUNT_W-1:0]        s2_count;
  logic                      en1;
  logic                      en2;
  logic                      en3;

  // Each stage moves when the one after it is empty or moving too.
  assign en3       = !out_valid || out_ready;
  assign en2       = !s2_valid || en3;
  assign en1       = !s1_valid || en2;
  assign pop_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= pop_valid;
      end
      if (en2) begin
        s2_valid <= s1_valid;
      end
      if (en3) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && pop_valid) begin
      s1_diff  <= $signed({1'b0, pop_data.match_count, 1'b0}) -
                  $signed({2'b00, pop_data.ops});
      s1_scale <= SCALE_W'(pop_data.alpha) * SCALE_W'(pop_data.kscale);
      s1_count <= pop_data.match_count;
    end
    if (en2 && s1_valid) begin
      s2_prod  <= PROD_W'(s1_diff) * PROD_W'($signed({1'b0, s1_scale}));
      s2_count <= s1_count;
    end
    if (en3 && s2_valid) begin
      if (s2_prod > ACT_HI) begin
        activation <= ACT_HI[ACT_W-1:0];
      end else if (s2_prod < ACT_LO) begin
        activation <= ACT_LO[ACT_W-1:0];
      end else begin
        activation <= s2_prod[ACT_W-1:0];
      end
      match_count <= s2_count;
    end
  end

  `XPBCA_ASSERT_NEXT(prod_held_in_stall, s2_valid && !en3, s2_valid && $stable(s2_prod))
  `XPBCA_ASSERT_NEXT(scale_zero_gives_zero, s1_valid && en2 && (s1_scale == '0), s2_prod == '0)

endmodule

// ===== sv/xnor_popcount_binary_conv_accumulate.sv =====
// ----------------------------------------------------------------------------
// XNOR popcount binary convolution accumulator
// Accumulates XNOR popcounts of packed bit words and emits the scaled
// activation (2*matches - bits_counted)*alpha*k on each last word.
// ----------------------------------------------------------------------------
//  channel  valid / ready          payload
//  input    in_valid / in_ready    source_bits weight_bits tap_in_bounds last_word
//                                  bits_counted channel_scale pixel_scale
//  output   out_valid / out_ready  activation match_count
//
// The front end takes one word per cycle while in_ready is high: a popcount stage,
// then the accumulator add. A taken last word's result passes the front stage, the
// close queue, two multiply stages and the saturating result register to out_valid.
// Reset (rst, synchronous) clears the accumulator, the queue and all valid bits.
// out_ready low fills the back pipeline and queue; only then does a last word
// hold the front stage and drop in_ready. Middle words never stall, padded or not.
module xnor_popcount_binary_conv_accumulate
  import xpbca_pkg::*;
#(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int MAX_COUNT = DEF_MAX_COUNT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [WORD_W-1:0]       source_bits,
  input  logic [WORD_W-1:0]       weight_bits,
  input  logic                    tap_in_bounds,
  input  logic                    last_word,
  input  logic [COUNT_W-1:0]      bits_counted,
  input  logic [SCALE_IN_W-1:0]   channel_scale,
  input  logic [SCALE_IN_W-1:0]   pixel_scale,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ACT_W-1:0] activation,
  output logic [COUNT_W-1:0]      match_count
);

  logic       q_push;
  logic       q_ready;
  close_rec_t q_wdata;
  logic       q_valid;
  logic       q_pop_ready;
  close_rec_t q_rdata;

  xpbca_front #(
    .WORD_BITS(WORD_BITS),
    .MAX_COUNT(MAX_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .source_bits  (source_bits),
    .weight_bits  (weight_bits),
    .tap_in_bounds(tap_in_bounds),
    .last_word    (last_word),
    .bits_counted (bits_counted),
    .channel_scale(channel_scale),
    .pixel_scale  (pixel_scale),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  xpbca_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .push_ready(q_ready),
    .pop_valid (q_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_rdata)
  );

  xpbca_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_rdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .activation (activation),
    .match_count(match_count)
  );

endmodule

// ===== test/xnor_popcount_binary_conv_accumulate_test.sv =====
// ----------------------------------------------------------------------------
// XNOR popcount accumulator testbench
// Streams packed source/weight words into the accumulator with random idle
// bursts on both channels, predicts every scaled activation and match count
// independently, and checks each output transaction in order.
// ----------------------------------------------------------------------------
module xnor_popcount_binary_conv_accumulate_test;
  import xpbca_pkg::*;

  localparam int WORD_BITS   = DEF_WORD_BITS;
  localparam int MAX_COUNT   = DEF_MAX_COUNT;
  localparam int COUNT_CAP   = (MAX_COUNT > ACC_FIELD_MAX) ? ACC_FIELD_MAX : MAX_COUNT;
  localparam logic [WORD_W-1:0] WORD_MASK =
    (WORD_BITS >= WORD_W) ? '1 : WORD_W'((64'd1 << WORD_BITS) - 64'd1);
  localparam longint ACT_MAX = (longint'(1) <<< (ACT_W - 1)) - 1;
  localparam longint ACT_MIN = -(longint'(1) <<< (ACT_W - 1));
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_LIMIT = 5000;

  typedef struct {
    logic signed [ACT_W-1:0] act;
    logic [COUNT_W-1:0]      count;
  } output_pos_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [WORD_W-1:0]       source_bits;
  logic [WORD_W-1:0]       weight_bits;
  logic                    tap_in_bounds;
  logic                    last_word;
  logic [COUNT_W-1:0]      bits_counted;
  logic [SCALE_IN_W-1:0]   channel_scale;
  logic [SCALE_IN_W-1:0]   pixel_scale;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [ACT_W-1:0] activation;
  logic [COUNT_W-1:0]      match_count;

  output_pos_t expected_outputs[$];
  int unsigned match_total = 0;
  int          fail_count = 0;
  int          words_taken = 0;
  int          words_offered = 0;
  int          outputs_checked = 0;
  int          cycle_count = 0;
  int          hold_len = 0;
  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;

  xnor_popcount_binary_conv_accumulate #(
    .WORD_BITS(WORD_BITS),
    .MAX_COUNT(MAX_COUNT)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .source_bits  (source_bits),
    .weight_bits  (weight_bits),
    .tap_in_bounds(tap_in_bounds),
    .last_word    (last_word),
    .bits_counted (bits_counted),
    .channel_scale(channel_scale),
    .pixel_scale  (pixel_scale),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .activation   (activation),
    .match_count  (match_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d outputs still pending",
               cycle_count, expected_outputs.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR: %s", msg);
  endfunction

  // Adds one accepted word to the running match total and, on the last word,
  // queues the scaled activation that the block must produce.
  function automatic void predict_word(input logic [WORD_W-1:0] src, input logic [WORD_W-1:0] wgt,
                                       input logic inb, input logic last,
                                       input logic [COUNT_W-1:0] ops,
                                       input logic [SCALE_IN_W-1:0] alpha,
                                       input logic [SCALE_IN_W-1:0] kscale);
    logic [WORD_W-1:0] agree;
    int unsigned       total;
    longint            diff;
    longint            gain;
    longint            scaled;
    output_pos_t       want;
    if (inb) begin
      agree = ~(src ^ wgt) & WORD_MASK;
      total = match_total + $countones(agree);
      match_total = (total > COUNT_CAP) ? COUNT_CAP : total;
    end
    if (last) begin
      diff = 2 * longint'(match_total) - longint'(ops);
      gain = longint'(alpha) * longint'(kscale);
      scaled = diff * gain;
      if (scaled > ACT_MAX) scaled = ACT_MAX;
      if (scaled < ACT_MIN) scaled = ACT_MIN;
      want.act = scaled[ACT_W-1:0];
      want.count = match_total[COUNT_W-1:0];
      expected_outputs.push_back(want);
      match_total = 0;
    end
  endfunction

  // Input and output transactions are both observed at the clock edge.
  always @(posedge clk) begin
    output_pos_t want;
    if (!rst && in_valid && in_ready) begin
      words_taken++;
      predict_word(source_bits, weight_bits, tap_in_bounds, last_word, bits_counted,
                   channel_scale, pixel_scale);
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_outputs.size() == 0) begin
        note_failure($sformatf("unexpected output: activation %0d match_count %0d",
                               activation, match_count));
      end else begin
        want = expected_outputs.pop_front();
        outputs_checked++;
        if (activation !== want.act)
          note_failure($sformatf("output %0d activation: expected %0d, got %0d",
                                 outputs_checked, want.act, activation));
        if (match_count !== want.count)
          note_failure($sformatf("output %0d match_count: expected %0d, got %0d",
                                 outputs_checked, want.count, match_count));
      end
    end
  end

  // Output side: random stall bursts, or one long hold when requested.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        out_ready <= 1'b1;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [WORD_W-1:0] src, input logic [WORD_W-1:0] wgt,
                           input logic inb, input logic last,
                           input logic [COUNT_W-1:0] ops,
                           input logic [SCALE_IN_W-1:0] alpha,
                           input logic [SCALE_IN_W-1:0] kscale);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    source_bits   <= src;
    weight_bits   <= wgt;
    tap_in_bounds <= inb;
    last_word     <= last;
    bits_counted  <= ops;
    channel_scale <= alpha;
    pixel_scale   <= kscale;
    words_offered++;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [SCALE_IN_W-1:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return SCALE_IN_W'(16'h1000);
      default: return SCALE_IN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // One output position of random words; the weight is often a near copy of
  // the source so that match counts spread over the whole range.
  task automatic send_position(input int n_words, input int pad_pct);
    logic [WORD_W-1:0]  src;
    logic [WORD_W-1:0]  wgt;
    logic [COUNT_W-1:0] ops;
    for (int i = 0; i < n_words; i++) begin
      src = $urandom;
      case ($urandom_range(0, 4))
        0: wgt = $urandom;
        1: wgt = src;
        2: wgt = ~src;
        3: wgt = src ^ (WORD_W'(1) << $urandom_range(0, WORD_W - 1));
        default: wgt = src ^ ($urandom & $urandom & $urandom);
      endcase
      case ($urandom_range(0, 4))
        0: ops = COUNT_W'(n_words * WORD_BITS);
        1: ops = COUNT_W'($urandom_range(0, 65536));
        2: ops = '0;
        default: ops = COUNT_W'($urandom_range(0, 131071));
      endcase
      send_word(src, wgt, $urandom_range(0, 99) >= pad_pct, i == n_words - 1, ops,
                pick_scale(), pick_scale());
    end
  endtask

  task automatic test_directed();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_word('1, '1, 1'b1, 1'b1, 17'd32, 16'h1000, 16'h1000);
    send_word('0, '1, 1'b1, 1'b1, 17'd32, 16'h1000, 16'h1000);
    send_word(32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b1, 17'd0, '1, '1);
    send_word(32'h1234_5678, 32'h1234_5678, 1'b1, 1'b1, 17'd0, '1, '1);
    // Op count far above the matches gives the most negative activation.
    send_word('0, '0, 1'b0, 1'b1, 17'h1FFFF, '1, '1);
    send_word(32'h0F0F_0F0F, 32'h0F0F_0F0F, 1'b1, 1'b1, 17'd65536, '1, '1);
    send_word(32'hDEAD_BEEF, 32'hDEAD_BEEF, 1'b1, 1'b1, 17'd10, 16'h0000, 16'h2000);
    send_word(32'hDEAD_BEEF, 32'hDEAD_BEEF, 1'b1, 1'b1, 17'd10, 16'h2000, 16'h0000);
    // Padding words add nothing, including a padded last word.
    send_word('1, '1, 1'b0, 1'b0, 17'd0, 16'h0001, 16'h0001);
    send_word(32'hFFFF_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 17'd0, 16'h0001, 16'h0001);
    send_word('1, '1, 1'b0, 1'b1, 17'd100, 16'h1800, 16'h0800);
    // A longer position with mixed taps.
    send_word(32'h8000_0001, 32'h8000_0001, 1'b1, 1'b0, 17'd0, '0, '0);
    send_word(32'h7FFF_FFFE, 32'h8000_0001, 1'b1, 1'b0, 17'd0, '0, '0);
    send_word(32'h0000_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 17'd0, '0, '0);
    send_word(32'h3333_3333, 32'h3333_CCCC, 1'b1, 1'b1, 17'd128, 16'hFFFF, 16'h0001);
    send_word('0, '0, 1'b1, 1'b1, 17'd0, 16'h0001, 16'hFFFF);
  endtask

  // Just enough all-agree words to drive the match count past its limit.
  task automatic test_count_saturation();
    logic [WORD_W-1:0] src;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (int i = 0; i < COUNT_CAP / WORD_BITS + 4; i++) begin
      src = $urandom;
      send_word(src, src, 1'b1, 1'b0, '0, '0, '0);
    end
    send_word('1, '1, 1'b1, 1'b1, 17'd0, '1, '1);
  endtask

  // The output side stops for a long time while last words keep coming, so the
  // block's queue fills and it must stall its input.
  task automatic test_output_stall();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_len = 200;
    for (int i = 0; i < 24; i++)
      send_word($urandom, $urandom, 1'b1, 1'b1, COUNT_W'($urandom_range(0, 131071)),
                pick_scale(), pick_scale());
  endtask

  task automatic random_positions(input int word_budget);
    int stop_at;
    int n;
    stop_at = words_offered + word_budget;
    while (words_offered < stop_at) begin
      case ($urandom_range(0, 9))
        0: n = $urandom_range(13, 40);
        1: n = 1;
        default: n = $urandom_range(2, 12);
      endcase
      // Now and then a position that is mostly or entirely padding.
      send_position(n, ($urandom_range(0, 9) == 0) ? $urandom_range(80, 100)
                                                    : $urandom_range(0, 30));
    end
  endtask

  task automatic test_random_traffic();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    random_positions(350);
  endtask

  task automatic test_random_steady();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    random_positions(150);
  endtask

  initial begin
    int waited;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    source_bits   <= '0;
    weight_bits   <= '0;
    tap_in_bounds <= 1'b0;
    last_word     <= 1'b0;
    bits_counted  <= '0;
    channel_scale <= '0;
    pixel_scale   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_count_saturation();
    test_output_stall();
    test_random_traffic();
    test_random_steady();
    in_valid <= 1'b0;

    waited = 0;
    while (expected_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (expected_outputs.size() != 0)
      note_failure($sformatf("%0d expected outputs never arrived", expected_outputs.size()));

    $display("Ran %0d words through the accumulator and checked %0d activations,", words_taken,
             outputs_checked);
    $display("with padding, count saturation, zero scales and a long output stall.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
